// ----- hdl/crs_pkg.sv -----
// crs_pkg: shared types, codes and defaults for the clip rectangle stack unit
// no dependencies; imported by clip_rectangle_stack_unit
package crs_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int LEVEL_W         = 8;
    localparam int CFG_IDX_W       = 2;

    localparam int SCREEN_LEFT_RST   = 0;
    localparam int SCREEN_TOP_RST    = 0;
    localparam int SCREEN_RIGHT_RST  = 1023;
    localparam int SCREEN_BOTTOM_RST = 767;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_RESET = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_PUSH_FULL = 2'd1,
        STAT_POP_EMPTY = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_LEFT   = 2'd0,
        CFG_SCREEN_TOP    = 2'd1,
        CFG_SCREEN_RIGHT  = 2'd2,
        CFG_SCREEN_BOTTOM = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

endpackage

// ----- hdl/clip_rectangle_stack_unit.sv -----
// clip_rectangle_stack_unit: in the accept cycle of a request the stack ram is
// read at the entry one below the current level; in the run state the pop data,
// the push intersection and the ram write-back are resolved and the result is
// loaded into the output register. The registered ram read is why a request
// is not executed in its accept cycle. A new request is taken while a finished
// result still waits in the output register; the run state holds only while
// that register is still full. No clearing pass follows reset.
// depends on crs_pkg and crs_ram
module clip_rectangle_stack_unit #(
    parameter int STACK_DEPTH  = crs_pkg::STACK_DEPTH_DEF,
    parameter int COORD_WIDTH  = crs_pkg::COORD_WIDTH_DEF,
    localparam int IN_W        = 2 + 4 * COORD_WIDTH,
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W       = 4 * COORD_WIDTH + crs_pkg::LEVEL_W + 2,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [crs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]         i_cfg_data,
    // request stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // command, win_left, win_top, win_right, win_bottom (lowest bit up)
    input  logic [IN_TDATA_W-1:0]          s_axis_tdata,
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // clip_left, clip_top, clip_right, clip_bottom, level, status (lowest bit up)
    output logic [OUT_TDATA_W-1:0]         m_axis_tdata
);

    import crs_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int AW = $clog2(STACK_DEPTH);

    // configuration
    logic signed [CW-1:0] r_scr_left, r_scr_top, r_scr_right, r_scr_bottom;

    // current state
    t_state               r_state, n_state;
    logic signed [CW-1:0] r_cur_left, r_cur_top, r_cur_right, r_cur_bottom;
    logic signed [CW-1:0] n_cur_left, n_cur_top, n_cur_right, n_cur_bottom;
    logic [LEVEL_W-1:0]   r_level, n_level;
    t_status              n_status;

    // latched request
    logic [1:0]           r_cmd;
    logic signed [CW-1:0] r_win_left, r_win_top, r_win_right, r_win_bottom;

    // output register
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;

    logic                 in_accept;
    logic                 run_go;
    logic [31:0]          lvl_ext, lvl_up, lvl_dn;
    logic                 push_ok;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [4*CW-1:0]      ram_wdata, ram_rdata;

    crs_ram #(
        .WIDTH (4 * CW),
        .DEPTH (STACK_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        s_axis_tready = 1'b0;
        run_go        = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_RUN:  run_go = !r_out_valid || m_axis_tready;
            default: begin
                s_axis_tready = 1'b0;
                run_go        = 1'b0;
            end
        endcase
    end

    assign in_accept = s_axis_tvalid && s_axis_tready;

    // level arithmetic and stack addressing
    always_comb begin
        lvl_ext   = 32'(r_level);
        lvl_up    = lvl_ext + 32'd1;
        lvl_dn    = lvl_ext - 32'd1;
        push_ok   = (r_level != {LEVEL_W{1'b1}}) && (lvl_up < 32'(STACK_DEPTH));
        ram_waddr = lvl_up[AW-1:0];
        // level zero wraps here, but that read is never used
        ram_raddr = lvl_dn[AW-1:0];
    end

    // command execution in the run state
    always_comb begin
        n_cur_left   = r_cur_left;
        n_cur_top    = r_cur_top;
        n_cur_right  = r_cur_right;
        n_cur_bottom = r_cur_bottom;
        n_level      = r_level;
        n_status     = STAT_OK;
        ram_we       = 1'b0;
        case (r_cmd)
            CMD_PUSH: begin
                if (push_ok) begin
                    n_cur_left   = (r_win_left > r_cur_left) ? r_win_left : r_cur_left;
                    n_cur_top    = (r_win_top > r_cur_top) ? r_win_top : r_cur_top;
                    n_cur_right  = (r_win_right < r_cur_right) ? r_win_right : r_cur_right;
                    n_cur_bottom = (r_win_bottom < r_cur_bottom) ? r_win_bottom
                                                                 : r_cur_bottom;
                    n_level      = lvl_up[LEVEL_W-1:0];
                    ram_we       = run_go;
                end else begin
                    if (r_level != {LEVEL_W{1'b1}}) begin
                        n_level = lvl_up[LEVEL_W-1:0];
                    end
                    n_status = STAT_PUSH_FULL;
                end
            end
            CMD_POP: begin
                if (r_level == '0) begin
                    n_status = STAT_POP_EMPTY;
                end else begin
                    if (lvl_dn == 32'd0) begin
                        n_cur_left   = r_scr_left;
                        n_cur_top    = r_scr_top;
                        n_cur_right  = r_scr_right;
                        n_cur_bottom = r_scr_bottom;
                    end else if (lvl_dn < 32'(STACK_DEPTH)) begin
                        n_cur_left   = $signed(ram_rdata[0*CW +: CW]);
                        n_cur_top    = $signed(ram_rdata[1*CW +: CW]);
                        n_cur_right  = $signed(ram_rdata[2*CW +: CW]);
                        n_cur_bottom = $signed(ram_rdata[3*CW +: CW]);
                    end
                    n_level = lvl_dn[LEVEL_W-1:0];
                end
            end
            CMD_RESET: begin
                n_cur_left   = r_scr_left;
                n_cur_top    = r_scr_top;
                n_cur_right  = r_scr_right;
                n_cur_bottom = r_scr_bottom;
                n_level      = '0;
            end
            default: begin
                n_status = STAT_OK;
            end
        endcase
    end

    assign ram_wdata = {n_cur_bottom, n_cur_right, n_cur_top, n_cur_left};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_left   <= CW'(SCREEN_LEFT_RST);
            r_scr_top    <= CW'(SCREEN_TOP_RST);
            r_scr_right  <= CW'(SCREEN_RIGHT_RST);
            r_scr_bottom <= CW'(SCREEN_BOTTOM_RST);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SCREEN_LEFT:   r_scr_left   <= $signed(i_cfg_data);
                CFG_SCREEN_TOP:    r_scr_top    <= $signed(i_cfg_data);
                CFG_SCREEN_RIGHT:  r_scr_right  <= $signed(i_cfg_data);
                CFG_SCREEN_BOTTOM: r_scr_bottom <= $signed(i_cfg_data);
                default:           r_scr_left   <= r_scr_left;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cur_left   <= CW'(SCREEN_LEFT_RST);
            r_cur_top    <= CW'(SCREEN_TOP_RST);
            r_cur_right  <= CW'(SCREEN_RIGHT_RST);
            r_cur_bottom <= CW'(SCREEN_BOTTOM_RST);
            r_level      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (run_go) begin
                r_cur_left   <= n_cur_left;
                r_cur_top    <= n_cur_top;
                r_cur_right  <= n_cur_right;
                r_cur_bottom <= n_cur_bottom;
                r_level      <= n_level;
                r_out_valid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // request and result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd        <= s_axis_tdata[1:0];
            r_win_left   <= $signed(s_axis_tdata[2 + 0*CW +: CW]);
            r_win_top    <= $signed(s_axis_tdata[2 + 1*CW +: CW]);
            r_win_right  <= $signed(s_axis_tdata[2 + 2*CW +: CW]);
            r_win_bottom <= $signed(s_axis_tdata[2 + 3*CW +: CW]);
        end
        if (run_go) begin
            r_out_data <= {n_status, n_level, n_cur_bottom, n_cur_right,
                           n_cur_top, n_cur_left};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_data);

    // a finished command always lands in the output register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        run_go |=> m_axis_tvalid)
        else $error("result not loaded after command completion");

    // level only moves when a command completes
    a_level_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !run_go |=> $stable(r_level))
        else $error("level changed without a completing command");

    // a stack write is only a successful push below saturation
    a_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_level != {LEVEL_W{1'b1}}) && (n_status == STAT_OK)
                   && (n_level == lvl_up[LEVEL_W-1:0]))
        else $error("stack write outside a stored push");

    // no new request is taken while the current one is still executing
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_RUN) && !s_axis_tready)
        else $error("request accepted during execution");

endmodule

// ----- hdl/crs_ram.sv -----
// crs_ram: generic single-write, single-read ram with registered read data
// no dependencies; used for the rectangle stack store
module crs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- test/clip_rectangle_stack_unit_tb.sv -----
// clip_rectangle_stack_unit_tb: self-checking bench for the clip rectangle stack unit
// drives push, pop, reset and unused-command requests with random gaps, predicts
// every result, compares them in order; depends on crs_pkg and clip_rectangle_stack_unit
module clip_rectangle_stack_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crs_pkg::*;

    localparam int CW           = COORD_WIDTH_DEF;
    localparam int DEPTH        = STACK_DEPTH_DEF;
    localparam int IN_W         = 2 + 4 * CW;
    localparam int IN_TW        = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W        = 4 * CW + LEVEL_W + 2;
    localparam int OUT_TW       = ((OUT_W + 7) / 8) * 8;
    localparam int LEVEL_MAX    = 255;
    localparam int IDLE_PCT     = 38;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 24;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] bottom;
        logic signed [CW-1:0] right;
        logic signed [CW-1:0] top;
        logic signed [CW-1:0] left;
    } t_rect;

    typedef struct packed {
        logic [IN_TW-IN_W-1:0] pad;
        t_rect                 win;
        logic [1:0]            cmd;
    } t_clip_req;

    typedef struct packed {
        logic [OUT_TW-OUT_W-1:0] pad;
        logic [1:0]              status;
        logic [LEVEL_W-1:0]      level;
        t_rect                   clip;
    } t_clip_res;

    typedef struct {
        logic [1:0] cmd;
        t_rect      win;
        bit         typed;
        t_clip_res  res;
    } t_dir_row;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CW-1:0]      i_cfg_data    = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_TW-1:0]   s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_TW-1:0]  m_axis_tdata;

    // predictor state
    t_rect     clip_cur;
    t_rect     clip_screen;
    t_rect     clip_stack [DEPTH];
    int        clip_level;
    t_clip_res clip_expq [$];

    t_dir_row  dir_rows [$];
    t_clip_res mon_got;
    t_clip_res mon_want;
    int        errors    = 0;
    int        sent      = 0;
    int        cycle_cnt = 0;
    int        idle_pct  = IDLE_PCT;

    clip_rectangle_stack_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL clip_rectangle_stack_unit");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    function automatic t_rect mk_rect(input int l, input int t, input int r, input int b);
        t_rect x;
        x.left   = l[CW-1:0];
        x.top    = t[CW-1:0];
        x.right  = r[CW-1:0];
        x.bottom = b[CW-1:0];
        return x;
    endfunction

    function automatic t_clip_res mk_res(input t_rect c, input int lvl, input logic [1:0] st);
        t_clip_res x;
        x        = '0;
        x.clip   = c;
        x.level  = lvl[LEVEL_W-1:0];
        x.status = st;
        return x;
    endfunction

    function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // advances the clip stack by one request and returns the result it yields
    function automatic t_clip_res clip_predict(input t_clip_req r);
        t_clip_res res;
        int        nxt;
        res        = '0;
        res.status = STAT_OK;
        case (r.cmd)
            CMD_PUSH: begin
                nxt = clip_level + 1;
                if (clip_level < LEVEL_MAX && nxt < DEPTH) begin
                    clip_cur.left   = smax(clip_cur.left, r.win.left);
                    clip_cur.top    = smax(clip_cur.top, r.win.top);
                    clip_cur.right  = smin(clip_cur.right, r.win.right);
                    clip_cur.bottom = smin(clip_cur.bottom, r.win.bottom);
                    clip_stack[nxt] = clip_cur;
                    clip_level      = nxt;
                end else begin
                    // over capacity: only the level moves, saturating
                    if (clip_level < LEVEL_MAX)
                        clip_level = nxt;
                    res.status = STAT_PUSH_FULL;
                end
            end
            CMD_POP: begin
                if (clip_level == 0) begin
                    res.status = STAT_POP_EMPTY;
                end else begin
                    clip_level = clip_level - 1;
                    if (clip_level == 0)
                        clip_cur = clip_screen;
                    else if (clip_level < DEPTH)
                        clip_cur = clip_stack[clip_level];
                end
            end
            CMD_RESET: begin
                clip_level = 0;
                clip_cur   = clip_screen;
            end
            default: ;
        endcase
        res.clip  = clip_cur;
        res.level = clip_level[LEVEL_W-1:0];
        return res;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            mon_got = m_axis_tdata;
            if (clip_expq.size() == 0) begin
                $display("%0t: result with no request pending, expected none, actual %h",
                         $time, m_axis_tdata);
                errors++;
            end else begin
                mon_want = clip_expq.pop_front();
                check_field("clip_left", mon_want.clip.left, mon_got.clip.left);
                check_field("clip_top", mon_want.clip.top, mon_got.clip.top);
                check_field("clip_right", mon_want.clip.right, mon_got.clip.right);
                check_field("clip_bottom", mon_want.clip.bottom, mon_got.clip.bottom);
                check_field("level", mon_want.level, mon_got.level);
                check_field("status", mon_want.status, mon_got.status);
            end
        end
    end

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_req(input t_clip_req r);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic issue(input logic [1:0] cmd, input t_rect win);
        t_clip_req r;
        r     = '0;
        r.cmd = cmd;
        r.win = win;
        send_req(r);
        clip_expq.push_back(clip_predict(r));
        sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (clip_expq.size() != 0);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CW-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic write_screen(input t_rect s);
        wait_drained();
        cfg_write(CFG_SCREEN_LEFT, s.left);
        cfg_write(CFG_SCREEN_TOP, s.top);
        cfg_write(CFG_SCREEN_RIGHT, s.right);
        cfg_write(CFG_SCREEN_BOTTOM, s.bottom);
        i_cfg_we <= 1'b0;
        clip_screen = s;
        @(posedge i_clk);
    endtask

    function automatic t_rect rand_win();
        return mk_rect($urandom, $urandom, $urandom, $urandom);
    endfunction

    // mostly windows that overlap the current clip so nesting stays non-trivial
    function automatic t_rect pick_win();
        if ($urandom_range(0, 9) < 3)
            return rand_win();
        return mk_rect(int'(clip_cur.left) + int'($urandom_range(0, 64)) - 24,
                       int'(clip_cur.top) + int'($urandom_range(0, 64)) - 24,
                       int'(clip_cur.right) - int'($urandom_range(0, 64)) + 24,
                       int'(clip_cur.bottom) - int'($urandom_range(0, 64)) + 24);
    endfunction

    function automatic t_rect screen_for(input int p);
        int l;
        int t;
        l = int'($urandom_range(0, 200)) - 100;
        t = int'($urandom_range(0, 200)) - 100;
        case (p)
            0:       return mk_rect(-32768, -32768, 32767, 32767);
            1:       return mk_rect(32767, 32767, -32768, -32768);
            4:       return mk_rect(SCREEN_LEFT_RST, SCREEN_TOP_RST,
                                    SCREEN_RIGHT_RST, SCREEN_BOTTOM_RST);
            6:       return mk_rect(-32768, 32767, 32767, -32768);
            3, 7:    return mk_rect(l, t, l + int'($urandom_range(0, 2000)),
                                    t + int'($urandom_range(0, 1500)));
            default: return rand_win();
        endcase
    endfunction

    task automatic random_item();
        int k;
        k = $urandom_range(0, 99);
        if (k < 42)
            issue(CMD_PUSH, pick_win());
        else if (k < 84)
            issue(CMD_POP, rand_win());
        else if (k < 92)
            issue(CMD_RESET, rand_win());
        else
            issue(CMD_UNUSED, rand_win());
    endtask

    task automatic run_phase(input int budget, input bit to_top);
        int start_cnt;
        int tgt;
        int n;
        if (to_top) begin
            // climb to the saturated level, then back down across the capacity
            while (clip_level < LEVEL_MAX)
                issue(CMD_PUSH, pick_win());
            repeat (3) issue(CMD_PUSH, pick_win());
            while (clip_level > DEPTH - 4)
                issue(CMD_POP, rand_win());
            issue(CMD_RESET, rand_win());
        end
        start_cnt = sent;
        while (sent - start_cnt < budget) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    repeat ($urandom_range(6, 16)) random_item();
                end
                4, 5, 6: begin
                    n = $urandom_range(1, 10);
                    repeat (n) issue(CMD_PUSH, pick_win());
                    if ($urandom_range(0, 1))
                        random_item();
                    repeat (n) issue(CMD_POP, rand_win());
                end
                7, 8: begin
                    tgt = $urandom_range(DEPTH - 2, DEPTH + 6);
                    while (clip_level < tgt)
                        issue(CMD_PUSH, pick_win());
                    while (clip_level > 0)
                        issue(CMD_POP, rand_win());
                    issue(CMD_POP, rand_win());
                end
                default: begin
                    issue(CMD_RESET, rand_win());
                end
            endcase
        end
    endtask

    function automatic void add_row(input logic [1:0] cmd, input t_rect win, input bit typed,
                                    input t_rect c, input int lvl, input logic [1:0] st);
        t_dir_row row;
        row.cmd   = cmd;
        row.win   = win;
        row.typed = typed;
        row.res   = mk_res(c, lvl, st);
        dir_rows.push_back(row);
    endfunction

    initial begin
        t_rect     scr0;
        t_rect     wide;
        t_rect     flip;
        t_rect     ones;
        t_clip_req req;
        t_clip_res pred;

        scr0 = mk_rect(SCREEN_LEFT_RST, SCREEN_TOP_RST, SCREEN_RIGHT_RST, SCREEN_BOTTOM_RST);
        wide = mk_rect(-32768, -32768, 32767, 32767);
        flip = mk_rect(32767, 32767, -32768, -32768);
        ones = mk_rect(-1, -1, -1, -1);
        clip_screen = scr0;
        clip_cur    = scr0;
        clip_level  = 0;

        add_row(CMD_POP, ones, 1, scr0, 0, STAT_POP_EMPTY);
        add_row(CMD_UNUSED, ones, 1, scr0, 0, STAT_OK);
        add_row(CMD_PUSH, wide, 1, scr0, 1, STAT_OK);
        add_row(CMD_PUSH, flip, 1, flip, 2, STAT_OK);
        add_row(CMD_PUSH, mk_rect(-1, -1, 0, 0), 0, scr0, 0, STAT_OK);
        add_row(CMD_POP, ones, 1, flip, 2, STAT_OK);
        add_row(CMD_POP, wide, 1, scr0, 1, STAT_OK);
        add_row(CMD_POP, flip, 1, scr0, 0, STAT_OK);
        add_row(CMD_POP, '0, 1, scr0, 0, STAT_POP_EMPTY);
        add_row(CMD_PUSH, mk_rect(100, 50, 500, 400), 0, scr0, 0, STAT_OK);
        add_row(CMD_PUSH, mk_rect(200, -10, 2000, 300), 0, scr0, 0, STAT_OK);
        add_row(CMD_PUSH, mk_rect(-5, 60, 450, 1000), 0, scr0, 0, STAT_OK);
        add_row(CMD_UNUSED, wide, 0, scr0, 0, STAT_OK);
        add_row(CMD_POP, '0, 0, scr0, 0, STAT_OK);
        // disjoint window leaves an empty rectangle that must pass through
        add_row(CMD_PUSH, mk_rect(600, 0, 700, 767), 0, scr0, 0, STAT_OK);
        add_row(CMD_PUSH, scr0, 0, scr0, 0, STAT_OK);
        add_row(CMD_POP, '0, 0, scr0, 0, STAT_OK);
        add_row(CMD_POP, '0, 0, scr0, 0, STAT_OK);
        add_row(CMD_RESET, '0, 1, scr0, 0, STAT_OK);
        add_row(CMD_RESET, ones, 1, scr0, 0, STAT_OK);
        add_row(CMD_PUSH, mk_rect(16'h5555, 16'haaaa, 16'h5555, 16'haaaa), 0, scr0, 0, STAT_OK);
        add_row(CMD_PUSH, mk_rect(16'haaaa, 16'h5555, 16'haaaa, 16'h5555), 0, scr0, 0, STAT_OK);
        add_row(CMD_POP, ones, 0, scr0, 0, STAT_OK);
        add_row(CMD_RESET, flip, 1, scr0, 0, STAT_OK);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            req     = '0;
            req.cmd = dir_rows[i].cmd;
            req.win = dir_rows[i].win;
            send_req(req);
            pred = clip_predict(req);
            clip_expq.push_back(dir_rows[i].typed ? dir_rows[i].res : pred);
            sent++;
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            idle_pct = (p == 2) ? 0 : IDLE_PCT;
            write_screen(screen_for(p));
            // sometimes keep the old clip so a later pop to level zero picks up the new screen
            if ($urandom_range(0, 3) != 0)
                issue(CMD_RESET, rand_win());
            run_phase(PHASE_ITEMS, p == 4);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("PASS clip_rectangle_stack_unit");
        else
            $display("FAIL clip_rectangle_stack_unit");
        $finish;
    end

endmodule
